FILE: design/palette_color_validator_core_defines.svh
// ----------------------------------------------------------------------------
// palette color validator assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef PALETTE_COLOR_VALIDATOR_CORE_DEFINES_SVH
`define PALETTE_COLOR_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcv check failed");

// next-cycle implication, checked outside reset
`define PCV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcv check failed");

`endif

FILE: design/pcv_pkg.sv
// ----------------------------------------------------------------------------
// pcv_pkg
// types and constants shared by the palette color validator modules
// ----------------------------------------------------------------------------
`default_nettype none

package pcv_pkg;

  // default store depths
  localparam int PCV_PAL_DEPTH  = 64;
  localparam int PCV_SEEN_DEPTH = 64;

  // register reset and field constants
  localparam logic [6:0] PCV_LIMIT_RST   = 7'd4;
  localparam logic [7:0] PCV_ALPHA_CLEAR = 8'h00;
  localparam logic [7:0] PCV_ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] PCV_COUNT_MAX   = 8'hff;

  // action codes
  localparam logic PCV_ACT_ADD   = 1'b0;
  localparam logic PCV_ACT_PIXEL = 1'b1;

  // input beat
  typedef struct packed {
    logic        action;
    logic [23:0] pixel_rgb;
    logic [7:0]  alpha;
    logic        last_in_image;
  } pcv_in_t;

  // result beat
  typedef struct packed {
    logic       bad_alpha;
    logic       not_in_palette;
    logic       palette_full;
    logic       image_done;
    logic [7:0] distinct_count;
    logic       too_many_colors;
  } pcv_out_t;

  // probe walking the cell chain
  typedef struct packed {
    logic        active;
    logic [23:0] pixel_rgb;
    logic [24:0] key;
    logic        pal_hit;
    logic        seen_hit;
  } pcv_probe_t;

endpackage

`default_nettype wire

FILE: design/pcv_cell.sv
// ----------------------------------------------------------------------------
// pcv_cell
// one chain cell: holds one palette entry and one seen-color entry where enabled,
// compares the passing probe against them and hands the probe to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module pcv_cell import pcv_pkg::*; #(
  parameter int IDX      = 0,
  parameter int PCW      = 7,
  parameter int SCW      = 7,
  parameter bit HAS_PAL  = 1'b1,
  parameter bit HAS_SEEN = 1'b1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pcv_probe_t       probe_i,
  output pcv_probe_t            probe_o,
  input  wire logic [PCW-1:0]   pal_cnt,
  input  wire logic [SCW-1:0]   seen_cnt,
  input  wire logic             pal_we,
  input  wire logic             seen_we,
  input  wire logic [23:0]      wr_rgb,
  input  wire logic [24:0]      wr_key
);

  logic       pal_match;
  logic       seen_match;
  logic       active_r;
  pcv_probe_t data_r, data_nxt;

  // palette entry
  if (HAS_PAL) begin : g_pal
    logic [23:0] pal_entry_r;

    always_ff @(posedge clk) begin
      if (pal_we) begin
        pal_entry_r <= wr_rgb;
      end
    end

    assign pal_match = (PCW'(IDX) < pal_cnt) && (pal_entry_r == probe_i.pixel_rgb);
  end else begin : g_no_pal
    assign pal_match = 1'b0;
  end

  // seen-color entry
  if (HAS_SEEN) begin : g_seen
    logic [24:0] seen_entry_r;

    always_ff @(posedge clk) begin
      if (seen_we) begin
        seen_entry_r <= wr_key;
      end
    end

    assign seen_match = (SCW'(IDX) < seen_cnt) && (seen_entry_r == probe_i.key);
  end else begin : g_no_seen
    assign seen_match = 1'b0;
  end

  // probe valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= probe_i.active;
    end
  end

  // probe payload with accumulated hits
  always_comb begin
    data_nxt          = probe_i;
    data_nxt.pal_hit  = probe_i.pal_hit | pal_match;
    data_nxt.seen_hit = probe_i.seen_hit | seen_match;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_comb begin
    probe_o        = data_r;
    probe_o.active = active_r;
  end

endmodule

`default_nettype wire

FILE: design/palette_color_validator_core.sv
// ----------------------------------------------------------------------------
// palette_color_validator_core
// checks rgba pixels against a loaded palette and counts distinct colors
// per image, using a chain of compare cells that a probe walks through
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | pcv_in_t  in_data
//  out_    | output    | out_valid/out_stall | pcv_out_t out_data
//  cfg_    | input     | cfg_we              | color_limit in cfg_data
//
//  an item walks a chain of CHAIN_LEN cells, CHAIN_LEN being the larger of the
//  two depths: the probe moves one cell per cycle, then the decision updates
//  state and registers the result, which moves to the output register once the
//  output slot is free. rst_n is synchronous and clears the counts, the limit
//  and the control; entries hold no reset. in_stall is high while an item is in
//  flight; a result may wait in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "palette_color_validator_core_defines.svh"

module palette_color_validator_core import pcv_pkg::*; #(
  parameter int PAL_DEPTH  = PCV_PAL_DEPTH,
  parameter int SEEN_DEPTH = PCV_SEEN_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pcv_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pcv_out_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic [6:0] cfg_data
);

  localparam int CHAIN_LEN = (PAL_DEPTH > SEEN_DEPTH) ? PAL_DEPTH : SEEN_DEPTH;
  localparam int PCW       = $clog2(PAL_DEPTH + 1);
  localparam int SCW       = $clog2(SEEN_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [6:0]     limit_r;
  logic [PCW-1:0] pal_cnt_r, pal_cnt_nxt;
  logic [SCW-1:0] seen_cnt_r, seen_cnt_nxt;
  logic [7:0]     total_r, total_nxt;
  logic [7:0]     total_upd;
  pcv_in_t        item_r;
  pcv_out_t       res_r, res_nxt;
  pcv_out_t       out_data_r;
  logic           out_valid_r, out_valid_nxt;

  logic           in_accept;
  logic           chain_exit;
  logic           last_exit;
  logic           slot_free;
  logic           alpha_zero;
  logic           alpha_opaque;
  logic           pal_wr;
  logic           seen_wr;
  pcv_probe_t     probe [CHAIN_LEN+1];
  pcv_probe_t     chain_out;
  logic [CHAIN_LEN-1:0] pal_we;
  logic [CHAIN_LEN-1:0] seen_we;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || !out_stall;

  // color limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= PCV_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  // accepted item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  // probe injected into the first cell
  always_comb begin
    probe[0].active    = in_accept;
    probe[0].pixel_rgb = in_data.pixel_rgb;
    probe[0].key       = (in_data.alpha == PCV_ALPHA_CLEAR) ? 25'd0
                                                             : {1'b1, in_data.pixel_rgb};
    probe[0].pal_hit   = 1'b0;
    probe[0].seen_hit  = 1'b0;
  end

  // cell chain and per-cell write enables
  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    if (i < PAL_DEPTH) begin : g_pwe
      assign pal_we[i] = pal_wr && (pal_cnt_r == PCW'(i));
    end else begin : g_no_pwe
      assign pal_we[i] = 1'b0;
    end

    if (i < SEEN_DEPTH) begin : g_swe
      assign seen_we[i] = seen_wr && (seen_cnt_r == SCW'(i));
    end else begin : g_no_swe
      assign seen_we[i] = 1'b0;
    end

    pcv_cell #(
      .IDX      (i),
      .PCW      (PCW),
      .SCW      (SCW),
      .HAS_PAL  (i < PAL_DEPTH),
      .HAS_SEEN (i < SEEN_DEPTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .probe_i  (probe[i]),
      .probe_o  (probe[i+1]),
      .pal_cnt  (pal_cnt_r),
      .seen_cnt (seen_cnt_r),
      .pal_we   (pal_we[i]),
      .seen_we  (seen_we[i]),
      .wr_rgb   (chain_out.pixel_rgb),
      .wr_key   (chain_out.key)
    );
  end

  assign chain_out    = probe[CHAIN_LEN];
  assign chain_exit   = (state_r == ST_RUN) && chain_out.active;
  assign last_exit    = chain_exit && (item_r.action == PCV_ACT_PIXEL) && item_r.last_in_image;
  assign alpha_zero   = (item_r.alpha == PCV_ALPHA_CLEAR);
  assign alpha_opaque = (item_r.alpha == PCV_ALPHA_OPAQUE);

  // item decision when the probe leaves the chain
  always_comb begin
    res_nxt      = '0;
    pal_wr       = 1'b0;
    seen_wr      = 1'b0;
    pal_cnt_nxt  = pal_cnt_r;
    seen_cnt_nxt = seen_cnt_r;
    total_nxt    = total_r;
    total_upd    = total_r;
    if (chain_exit) begin
      if (item_r.action == PCV_ACT_ADD) begin
        if (!alpha_zero) begin
          if (!alpha_opaque) begin
            res_nxt.bad_alpha = 1'b1;
          end else if (!chain_out.pal_hit) begin
            if (pal_cnt_r == PCW'(PAL_DEPTH)) begin
              res_nxt.palette_full = 1'b1;
            end else begin
              pal_wr      = 1'b1;
              pal_cnt_nxt = pal_cnt_r + PCW'(1);
            end
          end
        end
      end else begin
        res_nxt.bad_alpha      = !alpha_zero && !alpha_opaque;
        res_nxt.not_in_palette = !alpha_zero && (pal_cnt_r != '0) && !chain_out.pal_hit;
        if (!chain_out.seen_hit) begin
          if (total_r != PCV_COUNT_MAX) begin
            total_upd = total_r + 8'd1;
          end
          if (seen_cnt_r != SCW'(SEEN_DEPTH)) begin
            seen_wr      = 1'b1;
            seen_cnt_nxt = seen_cnt_r + SCW'(1);
          end
        end
        if (item_r.last_in_image) begin
          res_nxt.image_done      = 1'b1;
          res_nxt.distinct_count  = total_upd;
          res_nxt.too_many_colors = (total_upd > {1'b0, limit_r});
          seen_cnt_nxt            = '0;
          total_nxt               = '0;
        end else begin
          total_nxt = total_upd;
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (chain_out.active) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pal_cnt_r   <= '0;
      seen_cnt_r  <= '0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pal_cnt_r   <= pal_cnt_nxt;
      seen_cnt_r  <= seen_cnt_nxt;
      total_r     <= total_nxt;
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (chain_exit) begin
      res_r <= res_nxt;
    end
    if ((state_r == ST_HOLD) && slot_free) begin
      out_data_r <= res_r;
    end
  end

  // checks
  `PCV_ASSERT_IMP(a_exit_in_run, chain_out.active, state_r == ST_RUN)
  `PCV_ASSERT_IMP(a_pal_cnt_range, 1'b1, pal_cnt_r <= PCW'(PAL_DEPTH))
  `PCV_ASSERT_IMP(a_full_not_done, out_valid_r, !(out_data_r.palette_full && out_data_r.image_done))
  `PCV_ASSERT_NXT(a_last_clears, last_exit, (seen_cnt_r == '0) && (total_r == '0))

endmodule

`default_nettype wire

FILE: tb/palette_color_validator_core_tb.sv
// ----------------------------------------------------------------------------
// palette_color_validator_core_tb
// self-checking bench: a directed table, then random palette loads and
// images of random length, checked beat by beat against a behavioral model
// of the palette store, the per-image color tracker and the limit register
// ----------------------------------------------------------------------------
module palette_color_validator_core_tb import pcv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;

  // directed table row: beat, and a hand-typed result where one is given
  typedef struct packed {
    pcv_in_t  beat;
    logic     typed;
    pcv_out_t want;
  } dir_row_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  pcv_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pcv_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  // model state
  logic [23:0] pal_mem [PCV_PAL_DEPTH];
  int          pal_n;
  logic [24:0] seen_mem [PCV_SEEN_DEPTH];
  int          seen_n;
  int          distinct_n;
  logic [6:0]  limit_q;

  pcv_out_t    pending_q [$];
  int          err_cnt;
  bit          idle_on;
  logic [23:0] hue_pool [12];
  logic [23:0] last_rgb;
  dir_row_t    dir_tbl [$];

  palette_color_validator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // expected result of one beat; updates the model state
  function automatic pcv_out_t judge_beat(input pcv_in_t b);
    pcv_out_t    r;
    logic [24:0] key;
    bit          pal_hit;
    bit          seen_hit;
    r = '0;
    key = '0;
    pal_hit = 1'b0;
    seen_hit = 1'b0;
    for (int i = 0; i < pal_n; i++)
      if (pal_mem[i] == b.pixel_rgb) pal_hit = 1'b1;
    if (b.action == PCV_ACT_ADD) begin
      if (b.alpha != PCV_ALPHA_CLEAR) begin
        if (b.alpha != PCV_ALPHA_OPAQUE) begin
          r.bad_alpha = 1'b1;
        end else if (!pal_hit) begin
          if (pal_n >= PCV_PAL_DEPTH) begin
            r.palette_full = 1'b1;
          end else begin
            pal_mem[pal_n] = b.pixel_rgb;
            pal_n++;
          end
        end
      end
    end else begin
      // transparent pixels share key zero and skip the palette lookup
      if (b.alpha != PCV_ALPHA_CLEAR) begin
        r.bad_alpha = (b.alpha != PCV_ALPHA_OPAQUE);
        key = {1'b1, b.pixel_rgb};
        r.not_in_palette = (pal_n != 0) && !pal_hit;
      end
      for (int i = 0; i < seen_n; i++)
        if (seen_mem[i] == key) seen_hit = 1'b1;
      // untracked colors still count once the tracker is full
      if (!seen_hit) begin
        if (distinct_n < PCV_COUNT_MAX) distinct_n++;
        if (seen_n < PCV_SEEN_DEPTH) begin
          seen_mem[seen_n] = key;
          seen_n++;
        end
      end
      if (b.last_in_image) begin
        r.image_done = 1'b1;
        r.distinct_count = distinct_n[7:0];
        r.too_many_colors = (distinct_n > int'(limit_q));
        seen_n = 0;
        distinct_n = 0;
      end
    end
    return r;
  endfunction

  function automatic dir_row_t row(input logic act, input logic [23:0] rgb,
                                   input logic [7:0] alpha, input logic last,
                                   input logic typed, input logic bad,
                                   input logic miss, input logic [7:0] cnt,
                                   input logic many);
    dir_row_t d;
    d.beat.action = act;
    d.beat.pixel_rgb = rgb;
    d.beat.alpha = alpha;
    d.beat.last_in_image = last;
    d.typed = typed;
    d.want = '0;
    d.want.bad_alpha = bad;
    d.want.not_in_palette = miss;
    d.want.image_done = (act == PCV_ACT_PIXEL) && last;
    d.want.distinct_count = cnt;
    d.want.too_many_colors = many;
    return d;
  endfunction

  // mostly clean alpha, sometimes any byte
  function automatic logic [7:0] pick_alpha();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return PCV_ALPHA_OPAQUE;
    if (r < 80) return PCV_ALPHA_CLEAR;
    return 8'($urandom);
  endfunction

  // present one beat and wait for it to be taken
  task automatic push_beat(input pcv_in_t beat, input bit typed = 1'b0,
                           input pcv_out_t typed_res = '0);
    pcv_out_t want;
    while (idle_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    want = judge_beat(beat);
    pending_q.push_back(typed ? typed_res : want);
  endtask

  // sender pauses until every expected result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [6:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_q = value;
  endtask

  task automatic push_pixel(input logic [23:0] rgb, input logic [7:0] alpha,
                            input logic last);
    pcv_in_t b;
    b.action = PCV_ACT_PIXEL;
    b.pixel_rgb = rgb;
    b.alpha = alpha;
    b.last_in_image = last;
    push_beat(b);
  endtask

  task automatic push_add(input logic [23:0] rgb, input logic [7:0] alpha);
    pcv_in_t b;
    b.action = PCV_ACT_ADD;
    b.pixel_rgb = rgb;
    b.alpha = alpha;
    b.last_in_image = 1'($urandom);
    push_beat(b);
  endtask

  // random palette adds mixed with images of random length
  task automatic run_mix(input int n);
    int          left;
    int unsigned r;
    logic [23:0] rgb;
    left = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 20) begin
        rgb = ($urandom_range(1) == 0) ? hue_pool[$urandom_range(11)] : 24'($urandom);
        push_add(rgb, pick_alpha());
      end else begin
        r = $urandom_range(99);
        if (r < 45 && pal_n != 0) rgb = pal_mem[$urandom_range(pal_n - 1)];
        else if (r < 70) rgb = last_rgb;
        else rgb = 24'($urandom);
        last_rgb = rgb;
        left--;
        push_pixel(rgb, pick_alpha(), left == 0);
        if (left == 0) left = $urandom_range(1, 10);
      end
    end
  endtask

  // image of n pixels with fresh random colors, mostly opaque, some transparent
  task automatic run_wide_image(input int n);
    for (int k = 0; k < n; k++)
      push_pixel(24'($urandom), (k % 50 == 7) ? PCV_ALPHA_CLEAR : PCV_ALPHA_OPAQUE,
                 k == n - 1);
  endtask

  // receiver stalls at random
  initial begin
    forever begin
      @(posedge clk);
      out_stall <= idle_on && ($urandom_range(99) < 14);
    end
  end

  function automatic void check_field(input string tag, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, tag, want, got);
      err_cnt++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    pcv_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $realtime, out_data);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_field("bad_alpha", 8'(want.bad_alpha), 8'(out_data.bad_alpha));
        check_field("not_in_palette", 8'(want.not_in_palette),
                    8'(out_data.not_in_palette));
        check_field("palette_full", 8'(want.palette_full), 8'(out_data.palette_full));
        check_field("image_done", 8'(want.image_done), 8'(out_data.image_done));
        check_field("distinct_count", want.distinct_count, out_data.distinct_count);
        check_field("too_many_colors", 8'(want.too_many_colors),
                    8'(out_data.too_many_colors));
      end
    end
  end

  // watchdog on cycles with no beat moving
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  initial begin
    err_cnt = 0;
    pal_n = 0;
    seen_n = 0;
    distinct_n = 0;
    limit_q = PCV_LIMIT_RST;
    idle_on = 1'b1;
    last_rgb = 24'h0;
    foreach (hue_pool[i]) hue_pool[i] = 24'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset limit, palette starts empty
    dir_tbl = '{
      // empty palette never flags a color
      row(PCV_ACT_PIXEL, 24'hffffff, PCV_ALPHA_OPAQUE, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_PIXEL, 24'h123456, PCV_ALPHA_CLEAR,  1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_PIXEL, 24'h000000, 8'h80,            1'b1, 1'b1, 1'b1, 1'b0, 8'd3, 1'b0),
      // adds: transparent ignored, half alpha refused, duplicate ignored
      row(PCV_ACT_ADD,   24'habcdef, PCV_ALPHA_CLEAR,  1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_ADD,   24'habcdef, 8'h7f,            1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_ADD,   24'h000000, PCV_ALPHA_OPAQUE, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_ADD,   24'h000000, PCV_ALPHA_OPAQUE, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_ADD,   24'hffffff, PCV_ALPHA_OPAQUE, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0),
      // palette lookups
      row(PCV_ACT_PIXEL, 24'h000000, PCV_ALPHA_OPAQUE, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_PIXEL, 24'h00ff00, PCV_ALPHA_OPAQUE, 1'b0, 1'b1, 1'b0, 1'b1, 8'd0, 1'b0),
      row(PCV_ACT_PIXEL, 24'h00ff00, PCV_ALPHA_CLEAR,  1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_PIXEL, 24'hffffff, 8'h01,            1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_PIXEL, 24'h800000, 8'hfe,            1'b1, 1'b1, 1'b1, 1'b1, 8'd5, 1'b1),
      // one-pixel images
      row(PCV_ACT_PIXEL, 24'h000000, PCV_ALPHA_OPAQUE, 1'b1, 1'b1, 1'b0, 1'b0, 8'd1, 1'b0),
      row(PCV_ACT_PIXEL, 24'h000000, PCV_ALPHA_CLEAR,  1'b1, 1'b1, 1'b0, 1'b0, 8'd1, 1'b0),
      // half alpha counts as the opaque color, transparent ones merge
      row(PCV_ACT_PIXEL, 24'h00ff00, PCV_ALPHA_OPAQUE, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_PIXEL, 24'h00ff00, 8'h80,            1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_PIXEL, 24'h000000, PCV_ALPHA_CLEAR,  1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0),
      row(PCV_ACT_PIXEL, 24'h654321, PCV_ALPHA_CLEAR,  1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0)
    };
    foreach (dir_tbl[i]) push_beat(dir_tbl[i].beat, dir_tbl[i].typed, dir_tbl[i].want);

    // lowest limit, mixed traffic
    set_limit(7'd0);
    run_mix(40);

    // limit of 64, no idling: fill the palette, then wide images
    set_limit(7'd64);
    idle_on = 1'b0;
    while (pal_n < PCV_PAL_DEPTH) push_add(24'($urandom), PCV_ALPHA_OPAQUE);
    push_add(24'($urandom), PCV_ALPHA_OPAQUE);
    push_add(pal_mem[$urandom_range(PCV_PAL_DEPTH - 1)], PCV_ALPHA_OPAQUE);
    push_add(24'($urandom), 8'h33);
    push_add(24'($urandom), PCV_ALPHA_OPAQUE);
    run_wide_image(PCV_SEEN_DEPTH + 1);
    run_wide_image(270);

    // mid-range limit, full palette, idling back on
    set_limit(7'($urandom_range(1, 63)));
    idle_on = 1'b1;
    run_mix(40);

    set_limit(7'($urandom_range(1, 8)));
    run_mix(20);

    // wait out the pipeline for stray results
    settle();
    repeat (PCV_SEEN_DEPTH + 16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
